### design/delimited_field_splitter_macros.svh
// assertion macros for the delimited field splitter checker
`ifndef DELIMITED_FIELD_SPLITTER_MACROS_SVH
`define DELIMITED_FIELD_SPLITTER_MACROS_SVH

// condition implies consequence in the same cycle
`define DFS_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("dfs check failed");

// condition implies consequence in the next cycle
`define DFS_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("dfs check failed");

`endif

### design/dfs_pkg.sv
// shared types, constants and helper functions of the delimited field splitter
`default_nettype none

package dfs_pkg;

  localparam int PEND_DEPTH = 32;
  localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int PEND_CW    = $clog2(PEND_DEPTH + 1);
  localparam int WS_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EMPTY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIMIT = 3'd4;

  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [WS_W-1:0] WS_SPACE = 3'd0;
  localparam logic [WS_W-1:0] WS_TAB   = 3'd1;
  localparam logic [WS_W-1:0] WS_LF    = 3'd2;
  localparam logic [WS_W-1:0] WS_VT    = 3'd3;
  localparam logic [WS_W-1:0] WS_FF    = 3'd4;
  localparam logic [WS_W-1:0] WS_CR    = 3'd5;

  // kind of record the datapath builds
  localparam logic [1:0] REC_BARE  = 2'd0;
  localparam logic [1:0] REC_PEND  = 2'd1;
  localparam logic [1:0] REC_BYTE  = 2'd2;
  localparam logic [1:0] REC_CLOSE = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        field_end;
    logic        all_done;
    logic [15:0] field_count;
    logic        overflow;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic       latch;
    logic       drop;
    logic       emit;
    logic [1:0] rec_kind;
    logic       rec_done;
    logic       rec_last;
    logic       push;
    logic       set_ovf;
    logic       set_stopped;
    logic       set_content;
    logic       close;
    logic       flush_rst;
    logic       flush_inc;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic stopped;
    logic lim_hit;
    logic present;
    logic eos;
    logic is_delim;
    logic trim_ws;
    logic content;
    logic pend_full;
    logic flush_done;
    logic kept;
    logic close_stop;
  } status_t;

  // {hit, code} for ascii whitespace
  function automatic logic [WS_W:0] ws_decode(input logic [7:0] b);
    logic [WS_W:0] r;
    case (b)
      CH_SPACE: r = {1'b1, WS_SPACE};
      CH_TAB:   r = {1'b1, WS_TAB};
      CH_LF:    r = {1'b1, WS_LF};
      CH_VT:    r = {1'b1, WS_VT};
      CH_FF:    r = {1'b1, WS_FF};
      CH_CR:    r = {1'b1, WS_CR};
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ws_char(input logic [WS_W-1:0] code);
    logic [7:0] r;
    case (code)
      WS_TAB:  r = CH_TAB;
      WS_LF:   r = CH_LF;
      WS_VT:   r = CH_VT;
      WS_FF:   r = CH_FF;
      WS_CR:   r = CH_CR;
      default: r = CH_SPACE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/dfs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/dfs_ctrl.sv
// controller: sequences the records of one input beat
`default_nettype none

module dfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  dfs_pkg::status_t st,
  output dfs_pkg::cmd_t    cmd
);
  import dfs_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_FLUSH_RD = 3'd2;
  localparam logic [2:0] S_FLUSH_WR = 3'd3;
  localparam logic [2:0] S_BYTE     = 3'd4;
  localparam logic [2:0] S_DELIM    = 3'd5;
  localparam logic [2:0] S_EOS      = 3'd6;
  localparam logic [2:0] S_NOTICE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       eos_follows;

  assign item_stall  = rst || (state != S_IDLE);
  assign eos_follows = st.eos && !st.close_stop;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid && !rst) begin
          cmd.latch = 1'b1;
          if (st.stopped) begin
            cmd.drop = 1'b1;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (st.lim_hit) begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.rec_kind    = REC_BARE;
            cmd.rec_done    = 1'b1;
            cmd.rec_last    = 1'b1;
            cmd.set_stopped = 1'b1;
            cmd.finish      = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (!st.present) begin
          if (st.eos) begin
            state_next = S_EOS;
          end else begin
            state_next = S_IDLE;
          end
        end else if (st.is_delim) begin
          state_next = S_DELIM;
        end else if (st.trim_ws) begin
          // leading whitespace is dropped, interior whitespace is held
          if (st.content && !st.pend_full) begin
            cmd.push = 1'b1;
          end else if (st.content) begin
            cmd.set_ovf = 1'b1;
          end
          if (st.eos) begin
            state_next = S_EOS;
          end else if (st.content && st.pend_full) begin
            state_next = S_NOTICE;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.flush_rst = 1'b1;
          state_next    = S_FLUSH_RD;
        end
      end
      S_FLUSH_RD: begin
        if (st.flush_done) begin
          state_next = S_BYTE;
        end else begin
          state_next = S_FLUSH_WR;
        end
      end
      S_FLUSH_WR: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.rec_kind  = REC_PEND;
          cmd.flush_inc = 1'b1;
          state_next    = S_FLUSH_RD;
        end
      end
      S_BYTE: begin
        if (st.out_free) begin
          cmd.emit        = 1'b1;
          cmd.rec_kind    = REC_BYTE;
          cmd.rec_last    = !st.eos;
          cmd.set_content = 1'b1;
          if (st.eos) begin
            state_next = S_EOS;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DELIM: begin
        if (!st.kept || st.out_free) begin
          cmd.emit     = st.kept;
          cmd.rec_kind = REC_CLOSE;
          cmd.rec_done = st.close_stop;
          cmd.rec_last = !eos_follows;
          cmd.close    = 1'b1;
          if (eos_follows) begin
            state_next = S_EOS;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EOS: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.rec_kind = st.kept ? REC_CLOSE : REC_BARE;
          cmd.rec_done = 1'b1;
          cmd.rec_last = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_NOTICE: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.rec_kind = REC_BARE;
          cmd.rec_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### design/dfs_datapath.sv
// datapath: config registers, string state, pending whitespace store, output register
`default_nettype none

module dfs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  dfs_pkg::item_t                   item,
  output logic                             rec_valid,
  input  logic                             rec_stall,
  output dfs_pkg::rec_t                    rec,
  input  logic                             cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  dfs_pkg::cmd_t                    cmd,
  output dfs_pkg::status_t                 st
);
  import dfs_pkg::*;

  logic [7:0]         delimiter;
  logic               trim_en;
  logic               keep_empty;
  logic               limit_en;
  logic [15:0]        field_limit;

  item_t              item_q;
  logic [PEND_CW-1:0] pend_cnt;
  logic [PEND_CW-1:0] flush_idx;
  logic               content;
  logic [15:0]        completed;
  logic               stopped;
  logic               ovf;

  logic [WS_W:0]      ws;
  logic [WS_W-1:0]    ram_rdata;
  logic               kept;
  logic [15:0]        comp_inc;
  logic               str_end;
  rec_t               rec_next;

  assign ws       = ws_decode(item_q.in_byte);
  assign kept     = content || keep_empty;
  // saturating count of the field a close would complete
  assign comp_inc = (kept && (completed != 16'hFFFF)) ? completed + 16'd1 : completed;
  // end of string resets the per-string state
  assign str_end  = (cmd.drop && item.end_of_string) || (cmd.finish && item_q.end_of_string);

  assign st.out_free   = !rec_valid || !rec_stall;
  assign st.stopped    = stopped;
  assign st.lim_hit    = limit_en && (completed >= field_limit);
  assign st.present    = item_q.byte_present;
  assign st.eos        = item_q.end_of_string;
  assign st.is_delim   = (item_q.in_byte == delimiter);
  assign st.trim_ws    = trim_en && ws[WS_W];
  assign st.content    = content;
  assign st.pend_full  = (pend_cnt == PEND_CW'(PEND_DEPTH));
  assign st.flush_done = (flush_idx == pend_cnt);
  assign st.kept       = kept;
  assign st.close_stop = kept && limit_en && (comp_inc >= field_limit);

  dfs_ram #(
    .WIDTH (WS_W),
    .DEPTH (PEND_DEPTH)
  ) u_pend (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (pend_cnt[PEND_AW-1:0]),
    .wdata (ws[WS_W-1:0]),
    .raddr (flush_idx[PEND_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    rec_next             = '0;
    rec_next.all_done    = cmd.rec_done;
    rec_next.last        = cmd.rec_last;
    rec_next.overflow    = ovf;
    rec_next.field_count = completed;
    case (cmd.rec_kind)
      REC_PEND: begin
        rec_next.out_byte = ws_char(ram_rdata);
        rec_next.has_byte = 1'b1;
      end
      REC_BYTE: begin
        rec_next.out_byte = item_q.in_byte;
        rec_next.has_byte = 1'b1;
      end
      REC_CLOSE: begin
        rec_next.field_end   = 1'b1;
        rec_next.field_count = comp_inc;
      end
      default: begin
        rec_next.out_byte = '0;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter   <= DELIM_RESET;
      trim_en     <= 1'b0;
      keep_empty  <= 1'b0;
      limit_en    <= 1'b0;
      field_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIMITER:   delimiter   <= cfg_data[7:0];
        CFG_TRIM:        trim_en     <= cfg_data[0];
        CFG_KEEP_EMPTY:  keep_empty  <= cfg_data[0];
        CFG_LIMIT_EN:    limit_en    <= cfg_data[0];
        CFG_FIELD_LIMIT: field_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
    if (cmd.flush_rst) begin
      flush_idx <= '0;
    end else if (cmd.flush_inc) begin
      flush_idx <= flush_idx + PEND_CW'(1);
    end
    if (cmd.emit) begin
      rec <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (cmd.emit) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt  <= '0;
      content   <= 1'b0;
      completed <= '0;
      stopped   <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end else if (cmd.latch) begin
        ovf <= 1'b0;
      end
      if (str_end) begin
        pend_cnt  <= '0;
        content   <= 1'b0;
        completed <= '0;
        stopped   <= 1'b0;
      end else begin
        if (cmd.close || cmd.set_content) begin
          pend_cnt <= '0;
        end else if (cmd.push) begin
          pend_cnt <= pend_cnt + PEND_CW'(1);
        end
        if (cmd.close) begin
          content <= 1'b0;
        end else if (cmd.set_content) begin
          content <= 1'b1;
        end
        if (cmd.close) begin
          completed <= comp_inc;
        end
        if (cmd.set_stopped || (cmd.close && st.close_stop)) begin
          stopped <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/delimited_field_splitter.sv
// top level of the delimited field splitter
//
//   channel  signals                          direction  beat
//   item     item_valid / item_stall / item   in         one string byte or end mark
//   rec      rec_valid / rec_stall / rec      out        one output record
//   cfg      cfg_we / cfg_index / cfg_data    in         register write, no wait
//
// between accepts, an item with a field byte first flushes each held whitespace byte ahead
// of it through the flush read and write states, a delimiter or an overflow notice passes
// through its own state, an item that closes the string adds an end state, and an item
// that arrives while stopped is dropped without leaving idle; one record per output register load.
// rst is synchronous; the pending store needs no clearing pass after reset.
// a stalled rec channel holds the controller in its emitting state, and item_stall
// stays high from the accepting edge until the item's last record sits in the output register.
`default_nettype none

module delimited_field_splitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  dfs_pkg::item_t                 item,
  output logic                           rec_valid,
  input  logic                           rec_stall,
  output dfs_pkg::rec_t                  rec,
  input  logic                           cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dfs_pkg::*;

  cmd_t    cmd;
  status_t st;

  dfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  dfs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

### design/dfs_checker.sv
// port level checks of the delimited field splitter, bound to the top level
`default_nettype none

`include "delimited_field_splitter_macros.svh"

module dfs_checker (
  input logic          clk,
  input logic          rst,
  input logic          rec_valid,
  input logic          rec_stall,
  input dfs_pkg::rec_t rec
);

  // a stalled record stays put
  `DFS_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec))
  // a record never carries a byte and a field close together
  `DFS_ASSERT_NOW(a_byte_or_end, rec_valid, !(rec.has_byte && rec.field_end))
  // bare records carry a zero byte
  `DFS_ASSERT_NOW(a_bare_zero, rec_valid && !rec.has_byte, rec.out_byte == 8'd0)
  // the final record of a string or the limit is always the beat's last
  `DFS_ASSERT_NOW(a_done_last, rec_valid && rec.all_done, rec.last)
  // a field close always counts the field it closes
  `DFS_ASSERT_NOW(a_end_counted, rec_valid && rec.field_end, rec.field_count != 16'd0)

endmodule

bind delimited_field_splitter dfs_checker u_chk (.*);

`default_nettype wire

### tb/dfs_record_checker.sv
// record checker for the delimited field splitter: predicts records per item beat and compares
module dfs_record_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  dfs_pkg::item_t                  item,
  input  logic                            rec_valid,
  input  logic                            rec_stall,
  input  dfs_pkg::rec_t                   rec,
  input  logic                            cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import dfs_pkg::*;

  // register copies
  logic [7:0]  delim_q;
  logic        trim_q;
  logic        keep_q;
  logic        limit_on_q;
  logic [15:0] limit_q;

  // string state
  logic [7:0]  held_ws [PEND_DEPTH];
  int          held_n;
  logic        field_open;
  logic [15:0] closed_n;
  logic        halted;

  rec_t        item_recs[$];
  rec_t        expected_records[$];
  logic        ws_dropped;

  task automatic add_rec(input logic [7:0] b, input logic hb, input logic fe, input logic ad);
    rec_t r;
    r = '0;
    r.out_byte    = b;
    r.has_byte    = hb;
    r.field_end   = fe;
    r.all_done    = ad;
    r.field_count = closed_n;
    r.overflow    = ws_dropped;
    item_recs.push_back(r);
  endtask

  task automatic close_field(input logic at_end, output logic gave);
    gave = field_open || keep_q;
    held_n = 0;
    field_open = 1'b0;
    if (gave) begin
      if (closed_n != 16'hFFFF) closed_n++;
      if (limit_on_q && closed_n >= limit_q) begin
        halted = 1'b1;
        add_rec(8'd0, 1'b0, 1'b1, 1'b1);
      end else begin
        add_rec(8'd0, 1'b0, 1'b1, at_end);
      end
    end
  endtask

  task automatic split_item(input item_t it);
    logic gave;
    int   k;
    item_recs.delete();
    ws_dropped = 1'b0;
    if (!halted && limit_on_q && closed_n >= limit_q) begin
      // limit already met when the beat arrives
      halted = 1'b1;
      add_rec(8'd0, 1'b0, 1'b0, 1'b1);
    end else if (!halted) begin
      if (it.byte_present) begin
        if (it.in_byte == delim_q) begin
          close_field(1'b0, gave);
        end else if (trim_q &&
                     (it.in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR})) begin
          if (field_open) begin
            if (held_n < PEND_DEPTH) begin
              held_ws[held_n] = it.in_byte;
              held_n++;
            end else begin
              ws_dropped = 1'b1;
            end
          end
        end else begin
          for (k = 0; k < held_n; k++) add_rec(held_ws[k], 1'b1, 1'b0, 1'b0);
          held_n = 0;
          field_open = 1'b1;
          add_rec(it.in_byte, 1'b1, 1'b0, 1'b0);
        end
      end
      if (it.end_of_string && !halted) begin
        close_field(1'b1, gave);
        if (!gave) add_rec(8'd0, 1'b0, 1'b0, 1'b1);
      end
      // dropped whitespace with nothing else to say gets a notice record
      if (ws_dropped && item_recs.size() == 0) add_rec(8'd0, 1'b0, 1'b0, 1'b0);
    end
    if (it.end_of_string) begin
      held_n = 0;
      field_open = 1'b0;
      closed_n = '0;
      halted = 1'b0;
    end
    if (item_recs.size() > 0) item_recs[item_recs.size()-1].last = 1'b1;
    foreach (item_recs[i]) expected_records.push_back(item_recs[i]);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rec_t want;
    if (rst) begin
      delim_q    = DELIM_RESET;
      trim_q     = 1'b0;
      keep_q     = 1'b0;
      limit_on_q = 1'b0;
      limit_q    = '0;
      held_n     = 0;
      field_open = 1'b0;
      closed_n   = '0;
      halted     = 1'b0;
      mismatches = 0;
      expected_records.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELIMITER:   delim_q    = cfg_data[7:0];
          CFG_TRIM:        trim_q     = cfg_data[0];
          CFG_KEEP_EMPTY:  keep_q     = cfg_data[0];
          CFG_LIMIT_EN:    limit_on_q = cfg_data[0];
          CFG_FIELD_LIMIT: limit_q    = cfg_data[15:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) split_item(item);
      if (rec_valid && !rec_stall) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record expected none actual %p", $time, rec);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("out_byte", want.out_byte, rec.out_byte);
          check_field("has_byte", want.has_byte, rec.has_byte);
          check_field("field_end", want.field_end, rec.field_end);
          check_field("all_done", want.all_done, rec.all_done);
          check_field("field_count", want.field_count, rec.field_count);
          check_field("overflow", want.overflow, rec.overflow);
          check_field("last", want.last, rec.last);
        end
      end
    end
    outstanding = expected_records.size();
  end

endmodule

### tb/delimited_field_splitter_tb.sv
// testbench top for the delimited field splitter: stimulus, idling and verdict
module delimited_field_splitter_tb;
  import dfs_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  rec_valid;
  logic                  rec_stall;
  rec_t                  rec;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  bit                    idle_on = 1'b1;
  int                    items_sent = 0;
  logic [7:0]            delim_cfg = DELIM_RESET;

  delimited_field_splitter dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec        (rec),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dfs_record_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .rec_valid   (rec_valid),
    .rec_stall   (rec_stall),
    .rec         (rec),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

  // record side back-pressure
  initial begin
    rec_stall = 1'b0;
    forever begin
      @(negedge clk);
      rec_stall <= idle_on && ($urandom_range(0, 99) < 38);
    end
  end

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom);
      1:       return space_byte();
      default: return 8'(8'd97 + $urandom_range(0, 25));
    endcase
  endfunction

  // one item beat, held until accepted, then maybe a gap
  task automatic send(input logic [7:0] b, input logic present = 1'b1,
                      input logic eos = 1'b0);
    item_t it;
    it.in_byte       = b;
    it.byte_present  = present;
    it.end_of_string = eos;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    items_sent++;
    if (idle_on && $urandom_range(0, 99) < 38) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic close_string();
    send(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    wait (outstanding == 0);
    // items that give no record may still be in flight
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] d, input logic trim, input logic keep,
                            input logic lim_on, input logic [15:0] lim);
    delim_cfg = d;
    write_reg(CFG_DELIMITER, {8'd0, d});
    write_reg(CFG_TRIM, {15'd0, trim});
    write_reg(CFG_KEEP_EMPTY, {15'd0, keep});
    write_reg(CFG_LIMIT_EN, {15'd0, lim_on});
    write_reg(CFG_FIELD_LIMIT, lim);
  endtask

  // mostly well-formed strings: fields of words with whitespace runs, some long
  task automatic send_string();
    int n_fields, f, w, n;
    n_fields = $urandom_range(0, 4);
    for (f = 0; f < n_fields; f++) begin
      if (f > 0) send(delim_cfg);
      repeat ($urandom_range(0, 2)) send(space_byte());
      for (w = $urandom_range(0, 3); w > 0; w--) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 19) == 0) send(8'($urandom), 1'b0, 1'b0);
          send(text_byte());
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 3);
        repeat (n) send(space_byte());
      end
    end
    if ($urandom_range(0, 1)) close_string();
    else send(text_byte(), 1'b1, 1'b1);
  endtask

  initial begin
    int          phase, first_random, phase_start;
    logic [7:0]  d;
    logic [15:0] lim;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    set_config(DELIM_RESET, 1'b0, 1'b0, 1'b0, 16'd0);
    // extreme bytes, eos carried on a byte
    send(8'h00);
    send(DELIM_RESET);
    send(8'hFF, 1'b1, 1'b1);
    // empty fields not kept, end-only beat
    send(DELIM_RESET);
    send(DELIM_RESET);
    close_string();

    drain();
    set_config(";", 1'b1, 1'b1, 1'b0, 16'd0);
    send(CH_SPACE);
    send(CH_TAB);
    send("x");
    send(CH_SPACE);
    send(CH_SPACE);
    send("y");
    send(CH_CR);
    send(";");
    send(";");
    close_string();
    // trim switched off while whitespace is held
    send("p");
    send(CH_SPACE);
    send(CH_VT);
    drain();
    write_reg(CFG_TRIM, 16'd0);
    send("q", 1'b1, 1'b1);

    // whitespace delimiter, limit of zero
    drain();
    set_config(CH_SPACE, 1'b1, 1'b0, 1'b1, 16'd0);
    send("a");
    close_string();
    // limit lowered to the number of fields already closed
    drain();
    write_reg(CFG_FIELD_LIMIT, 16'hFFFF);
    send("a");
    send(CH_SPACE);
    send("b");
    drain();
    write_reg(CFG_FIELD_LIMIT, 16'd1);
    send("c");
    close_string();

    first_random = items_sent;
    phase = 0;
    while (items_sent - first_random < 400) begin
      drain();
      case ($urandom_range(0, 5))
        0:       d = DELIM_RESET;
        1:       d = 8'h00;
        2:       d = 8'hFF;
        3:       d = CH_SPACE;
        4:       d = CH_TAB;
        default: d = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       lim = 16'd0;
        1:       lim = 16'hFFFF;
        default: lim = 16'($urandom_range(1, 6));
      endcase
      set_config(d, $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 9) < 4, lim);
      idle_on = (phase != 2);
      phase_start = items_sent;
      while (items_sent - phase_start < 50) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 4))
            send(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
        end else begin
          send_string();
        end
      end
      phase++;
    end

    item_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
